// ===== hdl/tbst_pkg.sv =====
// ----------------------------------------------------------------------------
// Taken-branch skip table package
// Shared widths, the table entry layout and the index and tag functions.
// ----------------------------------------------------------------------------
package tbst_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 48;
  localparam int TAG_W         = 8;
  localparam int CNT_W         = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(3);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              active;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] end_addr;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] pc;
    logic              taken;
    logic [ADDR_W-1:0] taken_target;
    logic [ADDR_W-1:0] end_pc;
  } item_t;

  // The slot comes from pc bits 8:2; the table size is a power of two.
  function automatic logic [IDX_W-1:0] slot_of(input logic [ADDR_W-1:0] pc);
    logic [6:0] raw;
    raw = pc[8:2];
    return IDX_W'(raw);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] pc);
    return pc[17:10] ^ pc[27:20];
  endfunction

endpackage

// ===== hdl/tbst_table.sv =====
// ----------------------------------------------------------------------------
// Taken-branch skip table storage
// Entry memory with separate read and write ports, registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module tbst_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en,
  input  logic [tbst_pkg::IDX_W-1:0] rd_idx,
  output tbst_pkg::entry_t        rd_entry,
  input  tbst_pkg::wr_req_t       wr
);
  import tbst_pkg::*;

  entry_t                     mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_r;
  entry_t                     rd_data_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  // Entries never written since reset read back as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_entry = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== hdl/tbst_train.sv =====
// ----------------------------------------------------------------------------
// Taken-branch skip table training logic
// Decides the entry write-back, the hit report and the new skip flag.
// ----------------------------------------------------------------------------
module tbst_train (
  input  tbst_pkg::item_t   item,
  input  tbst_pkg::entry_t  entry,
  input  logic              skip_cur,
  output tbst_pkg::wr_req_t wr,
  output logic              prevent_hit,
  output logic              skip_nxt
);
  import tbst_pkg::*;

  logic [TAG_W-1:0] tag;
  logic             hit;
  logic [CNT_W-1:0] cnt_inc;

  assign tag     = tag_of(item.pc);
  assign hit     = (entry.tag == tag);
  assign cnt_inc = (entry.count == CNT_MAX) ? CNT_MAX : entry.count + CNT_W'(1);

  always_comb begin
    wr.en       = 1'b0;
    wr.idx      = slot_of(item.pc);
    wr.data     = entry;
    prevent_hit = 1'b0;
    skip_nxt    = skip_cur;

    unique case (item.cmd)
      CMD_LOOKUP: begin
        prevent_hit = hit && entry.active;
      end
      CMD_UPDATE: begin
        if (item.taken) begin
          priority if (!hit) begin
            wr.en            = 1'b1;
            wr.data.tag      = tag;
            wr.data.active   = 1'b0;
            wr.data.count    = '0;
            wr.data.target   = item.taken_target;
            wr.data.end_addr = item.end_pc;
            skip_nxt         = 1'b0;
          end else if (!entry.active) begin
            wr.en         = 1'b1;
            wr.data.count = cnt_inc;
            if (cnt_inc == CNT_MAX) begin
              wr.data.active = 1'b1;
              skip_nxt       = 1'b1;
            end else begin
              skip_nxt = 1'b0;
            end
          end else if (entry.count != CNT_MAX) begin
            wr.en         = 1'b1;
            wr.data.count = cnt_inc;
            skip_nxt      = 1'b1;
          end else begin
            // Saturated active entry: table and skip flag stay as they are.
            wr.en = 1'b0;
          end
        end else begin
          if (hit) begin
            wr.en = 1'b1;
            if (entry.active && entry.count == CNT_MAX) begin
              wr.data.count = '0;
            end else begin
              wr.data.tag = '0;
            end
          end
          skip_nxt = 1'b0;
        end
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/taken_branch_skip_table_unit.sv =====
// ----------------------------------------------------------------------------
// Taken-branch skip table
// Direct-mapped 128-entry table queried by lookups and trained by updates.
// ----------------------------------------------------------------------------
// For each word, busy rises for the cycle after start, while the
// registered memory read returns and the entry is modified and written back.
// The result appears with out_valid for one cycle right after that, and a new
// start is taken at the edge that ends the result cycle, so the block takes no
// new word until the last one has been read, modified and written back. The
// receiver cannot stall; every result is shown exactly once. The table reads
// as all zero after reset, with no clearing pass.
module taken_branch_skip_table_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [tbst_pkg::ADDR_W-1:0] in_pc,
  input  logic                        in_taken,
  input  logic [tbst_pkg::ADDR_W-1:0] in_taken_target,
  input  logic [tbst_pkg::ADDR_W-1:0] in_end_pc,
  output logic                        out_valid,
  output logic                        out_prevent_hit,
  output logic [tbst_pkg::ADDR_W-1:0] out_hit_target,
  output logic [tbst_pkg::ADDR_W-1:0] out_hit_end,
  output logic                        out_skip
);
  import tbst_pkg::*;

  logic              accept;
  item_t             item_r;
  logic              busy_r;
  logic              out_valid_r;
  logic              prevent_hit_r;
  logic              skip_r;
  logic [ADDR_W-1:0] last_target_r;
  logic [ADDR_W-1:0] last_end_r;

  entry_t            rd_entry;
  wr_req_t           train_wr;
  wr_req_t           wr;
  logic              prevent_hit_nxt;
  logic              skip_nxt;

  assign accept = start && !busy_r;

  tbst_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_idx   (slot_of(in_pc)),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  tbst_train u_train (
    .item        (item_r),
    .entry       (rd_entry),
    .skip_cur    (skip_r),
    .wr          (train_wr),
    .prevent_hit (prevent_hit_nxt),
    .skip_nxt    (skip_nxt)
  );

  always_comb begin
    wr    = train_wr;
    wr.en = train_wr.en && busy_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd          <= cmd_t'(in_cmd);
      item_r.pc           <= in_pc;
      item_r.taken        <= in_taken;
      item_r.taken_target <= in_taken_target;
      item_r.end_pc       <= in_end_pc;
    end
    if (busy_r) begin
      prevent_hit_r <= prevent_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      skip_r        <= 1'b0;
      last_target_r <= '0;
      last_end_r    <= '0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        skip_r <= skip_nxt;
        // A lookup latches the entry it read; updates repeat the last one.
        if (item_r.cmd == CMD_LOOKUP) begin
          last_target_r <= rd_entry.target;
          last_end_r    <= rd_entry.end_addr;
        end
      end
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_prevent_hit = prevent_hit_r;
  assign out_hit_target  = last_target_r;
  assign out_hit_end     = last_end_r;
  assign out_skip        = skip_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Taken-branch skip table testbench
// Drives lookup and training words through the start/busy handshake. A
// table model built alongside predicts each reply, and a monitor checks
// every strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  import tbst_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_WORDS = 1350;
  localparam int          POOL_SIZE    = 32;
  localparam int          TAIL_CYCLES  = 8;

  // Slot 1 with tag 1, a second address with a nonzero tag in a fresh slot,
  // and an address whose tag is 1 in slot 0.
  localparam logic [ADDR_W-1:0] PC_TRAIN = 48'h0000_0000_0404;
  localparam logic [ADDR_W-1:0] PC_COLD  = 48'h0000_0000_0C28;
  localparam logic [ADDR_W-1:0] PC_SLOT0 = 48'h0000_0010_0000;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef struct {
    cmd_t              cmd;
    logic [ADDR_W-1:0] pc;
    logic              taken;
    logic [ADDR_W-1:0] taken_target;
    logic [ADDR_W-1:0] end_pc;
    bit                drain;
  } word_t;

  typedef struct {
    logic              prevent_hit;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] end_addr;
    logic              skip;
  } reply_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic              in_cmd          = 1'b0;
  logic [ADDR_W-1:0] in_pc           = '0;
  logic              in_taken        = 1'b0;
  logic [ADDR_W-1:0] in_taken_target = '0;
  logic [ADDR_W-1:0] in_end_pc       = '0;
  logic              out_valid;
  logic              out_prevent_hit;
  logic [ADDR_W-1:0] out_hit_target;
  logic [ADDR_W-1:0] out_hit_end;
  logic              out_skip;

  // Table model state.
  logic [TAG_W-1:0]  tbl_tag    [TABLE_ENTRIES] = '{default: '0};
  logic              tbl_active [TABLE_ENTRIES] = '{default: '0};
  logic [CNT_W-1:0]  tbl_count  [TABLE_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0] tbl_target [TABLE_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0] tbl_end    [TABLE_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0] seen_target = '0;
  logic [ADDR_W-1:0] seen_end    = '0;
  logic              skip_state  = 1'b0;

  word_t  words_queued[$];
  reply_t replies_due[$];
  word_t  in_flight;
  bit     holding     = 1'b0;
  int     total_words = 0;
  int     words_taken = 0;
  int     n_lookup    = 0;
  int     n_update    = 0;
  int     n_hit       = 0;
  int     n_skip      = 0;
  int     failures    = 0;
  int     cycle_count = 0;

  taken_branch_skip_table_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_pc           (in_pc),
    .in_taken        (in_taken),
    .in_taken_target (in_taken_target),
    .in_end_pc       (in_end_pc),
    .out_valid       (out_valid),
    .out_prevent_hit (out_prevent_hit),
    .out_hit_target  (out_hit_target),
    .out_hit_end     (out_hit_end),
    .out_skip        (out_skip)
  );

  always #5 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic void queue_word(cmd_t c, logic [ADDR_W-1:0] pc, logic tk,
                                     logic [ADDR_W-1:0] tgt, logic [ADDR_W-1:0] ea,
                                     bit drain);
    word_t w;
    w.cmd          = c;
    w.pc           = pc;
    w.taken        = tk;
    w.taken_target = tgt;
    w.end_pc       = ea;
    w.drain        = drain;
    words_queued.push_back(w);
  endfunction

  // Applies one word to the table model and returns the reply it produces.
  function automatic reply_t resolve_word(input word_t w);
    reply_t           r;
    logic [IDX_W-1:0] row;
    logic [TAG_W-1:0] key;
    logic             match;
    row   = w.pc[8:2];
    key   = w.pc[17:10] ^ w.pc[27:20];
    match = (tbl_tag[row] == key);
    r.prevent_hit = 1'b0;
    if (w.cmd == CMD_LOOKUP) begin
      seen_target   = tbl_target[row];
      seen_end      = tbl_end[row];
      r.prevent_hit = match && tbl_active[row];
    end else if (w.taken) begin
      if (!match) begin
        tbl_tag[row]    = key;
        tbl_active[row] = 1'b0;
        tbl_count[row]  = '0;
        tbl_target[row] = w.taken_target;
        tbl_end[row]    = w.end_pc;
        skip_state      = 1'b0;
      end else if (!tbl_active[row]) begin
        if (tbl_count[row] != CNT_MAX) tbl_count[row] = tbl_count[row] + 1'b1;
        if (tbl_count[row] == CNT_MAX) begin
          tbl_active[row] = 1'b1;
          skip_state      = 1'b1;
        end else begin
          skip_state = 1'b0;
        end
      end else if (tbl_count[row] != CNT_MAX) begin
        tbl_count[row] = tbl_count[row] + 1'b1;
        skip_state     = 1'b1;
      end
      // An active, saturated entry hit by a taken branch leaves everything as is.
    end else begin
      if (match) begin
        if (tbl_active[row] && tbl_count[row] == CNT_MAX) tbl_count[row] = '0;
        else tbl_tag[row] = '0;
      end
      skip_state = 1'b0;
    end
    r.target   = seen_target;
    r.end_addr = seen_end;
    r.skip     = skip_state;
    return r;
  endfunction

  always @(posedge clk) begin : drive_words
    word_t nxt;
    int    gap;
    bit    launch;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      launch = 1'b0;
      if (start && !busy) begin
        replies_due.push_back(resolve_word(in_flight));
        if (in_flight.cmd == CMD_LOOKUP) n_lookup++;
        else n_update++;
        words_taken++;
        holding = 1'b0;
      end
      if (words_taken < total_words / 3) gap = 23;
      else if (words_taken < 2 * total_words / 3) gap = 64;
      else gap = 0;
      if (!holding && words_queued.size() > 0) begin
        nxt = words_queued[0];
        // A draining word waits until every outstanding reply has come back.
        if ((!nxt.drain || replies_due.size() == 0) && $urandom_range(99) >= gap) begin
          void'(words_queued.pop_front());
          in_flight = nxt;
          holding   = 1'b1;
          launch    = 1'b1;
        end
      end
      if (launch) begin
        in_cmd          <= nxt.cmd;
        in_pc           <= nxt.pc;
        in_taken        <= nxt.taken;
        in_taken_target <= nxt.taken_target;
        in_end_pc       <= nxt.end_pc;
      end else if (!holding) begin
        in_cmd          <= 1'($urandom_range(1));
        in_pc           <= rand_addr();
        in_taken        <= 1'($urandom_range(1));
        in_taken_target <= rand_addr();
        in_end_pc       <= rand_addr();
      end
      start <= holding;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result strobed with no word outstanding", $time);
        failures++;
      end else begin
        want = replies_due.pop_front();
        if (out_prevent_hit) n_hit++;
        if (out_skip) n_skip++;
        if (out_prevent_hit !== want.prevent_hit) begin
          $display("%0t: prevent_hit expected %0d actual %0d", $time,
                   want.prevent_hit, out_prevent_hit);
          failures++;
        end
        if (out_hit_target !== want.target) begin
          $display("%0t: hit_target expected %h actual %h", $time,
                   want.target, out_hit_target);
          failures++;
        end
        if (out_hit_end !== want.end_addr) begin
          $display("%0t: hit_end expected %h actual %h", $time,
                   want.end_addr, out_hit_end);
          failures++;
        end
        if (out_skip !== want.skip) begin
          $display("%0t: skip expected %0d actual %0d", $time, want.skip, out_skip);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d replies outstanding", $time,
               replies_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    logic [ADDR_W-1:0] pc;
    int                directed;
    int                r;
    int                run;

    // Cleared entries hold tag 0, so pc 0 matches an inactive entry.
    queue_word(CMD_LOOKUP, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b0);
    queue_word(CMD_UPDATE, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b0);
    // Allocate, then three taken hits make the entry active.
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b1, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654, 1'b0);
    repeat (3) queue_word(CMD_UPDATE, PC_TRAIN, 1'b1, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_LOOKUP, PC_TRAIN, 1'b0, '0, '0, 1'b0);
    // Saturated and active: a taken hit keeps the skip flag as it was.
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b1, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b0, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b1, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b1, rand_addr(), rand_addr(), 1'b0);
    // Not taken on an active entry below saturation clears the tag.
    queue_word(CMD_UPDATE, PC_TRAIN, 1'b0, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_LOOKUP, PC_TRAIN, 1'b1, ALL_ONES, '0, 1'b0);
    queue_word(CMD_UPDATE, PC_COLD, 1'b0, rand_addr(), rand_addr(), 1'b0);
    // All-ones pc has tag 0 in the last slot; bits above 27 play no part.
    queue_word(CMD_UPDATE, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 1'b0);
    queue_word(CMD_LOOKUP, ALL_ONES, 1'b0, '0, '0, 1'b0);
    queue_word(CMD_UPDATE, 48'hFFFF_F000_0000, 1'b1, rand_addr(), rand_addr(), 1'b0);
    queue_word(CMD_UPDATE, PC_SLOT0, 1'b1, '0, '0, 1'b0);
    queue_word(CMD_LOOKUP, PC_SLOT0, 1'b0, ALL_ONES, ALL_ONES, 1'b0);
    queue_word(CMD_LOOKUP, 48'hFFFF_F000_0000, 1'b0, '0, '0, 1'b0);
    directed = words_queued.size();

    // A small pool of addresses so that slots collide and entries get trained.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = rand_addr();
      if (i % 4 == 1) pool[i][8:2] = pool[i - 1][8:2];
      if (i % 8 == 3) pool[i][27:20] = pool[i][17:10];
    end

    while (words_queued.size() < directed + RANDOM_WORDS) begin
      pc = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)] : rand_addr();
      r  = $urandom_range(99);
      if (r < 20) begin
        run = $urandom_range(6, 3);
        repeat (run) queue_word(CMD_UPDATE, pc, 1'b1, rand_addr(), rand_addr(), 1'b0);
        queue_word(CMD_LOOKUP, pc, 1'($urandom_range(1)), rand_addr(), rand_addr(), 1'b0);
      end else if (r < 45) begin
        queue_word(CMD_LOOKUP, pc, 1'($urandom_range(1)), rand_addr(), rand_addr(), 1'b0);
      end else if (r < 75) begin
        queue_word(CMD_UPDATE, pc, 1'b1, rand_addr(), rand_addr(), 1'b0);
      end else if (r < 90) begin
        queue_word(CMD_UPDATE, pc, 1'b0, rand_addr(), rand_addr(), 1'b0);
      end else begin
        queue_word(cmd_t'($urandom_range(1)), rand_addr(), 1'($urandom_range(1)),
                   rand_addr(), rand_addr(), 1'b0);
      end
    end
    total_words = words_queued.size();
    // Drain before the random part, at the idle phase changes and now and then.
    for (int i = directed; i < total_words; i += 200) words_queued[i].drain = 1'b1;
    words_queued[total_words / 3].drain     = 1'b1;
    words_queued[2 * total_words / 3].drain = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (words_queued.size() > 0 || holding || replies_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d words: %0d lookups with %0d hits, %0d training updates,",
             words_taken, n_lookup, n_hit, n_update);
    $display("%0d replies with skip set, %0d mismatches", n_skip, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
